// ----- src/kruskal_union_find_edge_filter_defines.svh -----
// assertion macros shared by the edge filter modules
// each expects i_clk and i_rst_n in the enclosing module
`ifndef KRUSKAL_UNION_FIND_EDGE_FILTER_DEFINES_SVH
`define KRUSKAL_UNION_FIND_EDGE_FILTER_DEFINES_SVH

// same-cycle implication
`define KUF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KUF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/kuf_pkg.sv -----
package kuf_pkg;

    localparam int unsigned MAX_VERTICES_DEF = 1024;
    localparam int unsigned QUEUE_DEPTH      = 2;

    localparam int unsigned VERTEX_W = 11;
    localparam int unsigned WEIGHT_W = 16;
    localparam int unsigned TAG_W    = 16;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned COUNT_W  = 10;
    localparam int unsigned EPOCH_W  = 4;

    localparam logic [VERTEX_W-1:0] VCOUNT_RESET = VERTEX_W'(1024);
    localparam logic [SUM_W-1:0]    SUM_MAX      = '1;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
    // epoch zero marks a swept entry, so live epochs run first..last
    localparam logic [EPOCH_W-1:0]  EPOCH_FIRST  = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0]  EPOCH_LAST   = '1;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
        logic [WEIGHT_W-1:0] weight;
        logic [TAG_W-1:0]    tag;
        logic                last;
        logic                bad;
        logic                self_loop;
    } t_edge_cmd;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic               accepted;
        logic               bad_vertex;
        logic [SUM_W-1:0]   total;
        logic [COUNT_W-1:0] taken;
        logic               complete;
        logic               last;
    } t_result;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND_A,
        S_FIND_B,
        S_LINK,
        S_DONE
    } t_back_state;

endpackage

// ----- src/kuf_queue.sv -----
`include "kruskal_union_find_edge_filter_defines.svh"

module kuf_queue #(
    parameter int unsigned DEPTH = kuf_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  kuf_pkg::t_edge_cmd  i_push_data,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output kuf_pkg::t_edge_cmd  o_head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    kuf_pkg::t_edge_cmd r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rd_ptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = CW'(r_count + 1'b1);
        end else if (i_pop && !i_push) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    `KUF_ASSERT_IMPL(a_q_no_overflow, i_push && !i_pop, !o_full, "push into full queue")
    `KUF_ASSERT_IMPL(a_q_no_underflow, i_pop, !o_empty, "pop from empty queue")

endmodule

// ----- src/kuf_front.sv -----
module kuf_front #(
    parameter int unsigned MAX_VERTICES = kuf_pkg::MAX_VERTICES_DEF
) (
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [kuf_pkg::VERTEX_W-1:0]     i_first_vertex,
    input  logic [kuf_pkg::VERTEX_W-1:0]     i_second_vertex,
    input  logic [kuf_pkg::WEIGHT_W-1:0]     i_edge_weight,
    input  logic [kuf_pkg::TAG_W-1:0]        i_edge_tag,
    input  logic                             i_last_edge,
    input  logic [kuf_pkg::VERTEX_W-1:0]     i_vertex_count,
    input  logic                             i_full,
    input  kuf_pkg::t_back_status            i_status,
    output logic                             o_push,
    output kuf_pkg::t_edge_cmd               o_cmd
);

    function automatic logic vertex_ok(
        input logic [kuf_pkg::VERTEX_W-1:0] v,
        input logic [kuf_pkg::VERTEX_W-1:0] vcount
    );
        logic ok;
        ok = (v != '0) && (v <= vcount) && (32'(v) <= MAX_VERTICES);
        return ok;
    endfunction

    logic bad;

    // no transactions while the parent table is being swept
    assign o_in_ready = !i_full && !i_status.clearing;
    assign o_push     = i_in_valid && o_in_ready;

    assign bad = !(vertex_ok(i_first_vertex, i_vertex_count) &&
                   vertex_ok(i_second_vertex, i_vertex_count));

    always_comb begin
        o_cmd.vertex_a  = i_first_vertex;
        o_cmd.vertex_b  = i_second_vertex;
        o_cmd.weight    = i_edge_weight;
        o_cmd.tag       = i_edge_tag;
        o_cmd.last      = i_last_edge;
        o_cmd.bad       = bad;
        o_cmd.self_loop = !bad && (i_first_vertex == i_second_vertex);
    end

endmodule

// ----- src/kuf_back.sv -----
`include "kruskal_union_find_edge_filter_defines.svh"

module kuf_back #(
    parameter int unsigned MAX_VERTICES = kuf_pkg::MAX_VERTICES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  kuf_pkg::t_edge_cmd           i_head,
    output logic                         o_pop,
    input  logic [kuf_pkg::VERTEX_W-1:0] i_vertex_count,
    output kuf_pkg::t_back_status        o_status,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output kuf_pkg::t_result             o_result
);

    localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned EW = kuf_pkg::EPOCH_W + AW;
    localparam int unsigned SW = kuf_pkg::SUM_W;
    localparam int unsigned VW = kuf_pkg::VERTEX_W;

    // entry: epoch tag over parent index; tag != current epoch means root
    logic [EW-1:0] mem [MAX_VERTICES];

    kuf_pkg::t_back_state r_state, n_state;
    kuf_pkg::t_edge_cmd   r_cmd;
    kuf_pkg::t_result     r_result;

    logic [EW-1:0]               r_rd_data;
    logic [AW-1:0]               r_cur;
    logic [AW-1:0]               r_root_a;
    logic [AW-1:0]               r_root_b;
    logic                        r_take;
    logic [SW-1:0]               r_sum;
    logic [kuf_pkg::COUNT_W-1:0] r_cnt;
    logic [kuf_pkg::EPOCH_W-1:0] r_epoch;
    logic [AW-1:0]               r_clr_addr;
    logic                        r_out_valid;

    logic [AW-1:0]               rd_addr;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [EW-1:0]               mem_wdata;
    logic                        out_load;
    logic                        take;
    logic                        rd_root;
    logic [AW-1:0]               rd_parent;
    logic [AW-1:0]               head_idx_a;
    logic [AW-1:0]               cmd_idx_b;
    logic [SW:0]                 sum_ext;
    logic [SW-1:0]               sum_sat;
    logic                        complete;

    assign rd_root    = (r_rd_data[AW +: kuf_pkg::EPOCH_W] != r_epoch);
    assign rd_parent  = r_rd_data[AW-1:0];
    assign head_idx_a = AW'(i_head.vertex_a - VW'(1));
    assign cmd_idx_b  = AW'(r_cmd.vertex_b - VW'(1));
    assign take       = (r_root_a != r_root_b);
    assign out_load   = (r_state == kuf_pkg::S_DONE) && (!r_out_valid || i_out_ready);

    assign sum_ext  = {1'b0, r_sum} + (SW + 1)'(r_cmd.weight);
    assign sum_sat  = sum_ext[SW] ? kuf_pkg::SUM_MAX : sum_ext[SW-1:0];
    assign complete = r_cmd.last &&
                      ((VW'(r_cnt) + VW'(1)) >= i_vertex_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kuf_pkg::S_CLEAR: begin
                if (r_clr_addr == AW'(MAX_VERTICES - 1)) begin
                    n_state = kuf_pkg::S_IDLE;
                end
            end
            kuf_pkg::S_IDLE: begin
                if (!i_empty) begin
                    if (i_head.bad || i_head.self_loop) begin
                        n_state = kuf_pkg::S_DONE;
                    end else begin
                        n_state = kuf_pkg::S_FIND_A;
                    end
                end
            end
            kuf_pkg::S_FIND_A: begin
                if (rd_root) begin
                    n_state = kuf_pkg::S_FIND_B;
                end
            end
            kuf_pkg::S_FIND_B: begin
                if (rd_root) begin
                    n_state = kuf_pkg::S_LINK;
                end
            end
            kuf_pkg::S_LINK: begin
                n_state = kuf_pkg::S_DONE;
            end
            kuf_pkg::S_DONE: begin
                if (out_load) begin
                    if (r_cmd.last && (r_epoch == kuf_pkg::EPOCH_LAST)) begin
                        n_state = kuf_pkg::S_CLEAR;
                    end else begin
                        n_state = kuf_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = kuf_pkg::S_CLEAR;
            end
        endcase
    end

    // per-state outputs: queue pop, table read and write
    always_comb begin
        o_pop     = 1'b0;
        rd_addr   = r_cur;
        mem_we    = 1'b0;
        mem_waddr = r_root_b;
        mem_wdata = {r_epoch, r_root_a};
        unique case (r_state)
            kuf_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            kuf_pkg::S_IDLE: begin
                o_pop   = !i_empty;
                rd_addr = head_idx_a;
            end
            kuf_pkg::S_FIND_A: begin
                rd_addr = rd_root ? cmd_idx_b : rd_parent;
            end
            kuf_pkg::S_FIND_B: begin
                rd_addr = rd_parent;
            end
            kuf_pkg::S_LINK: begin
                mem_we = take;
            end
            kuf_pkg::S_DONE: begin
                rd_addr = r_cur;
            end
            default: begin
                rd_addr = r_cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kuf_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_epoch     <= kuf_pkg::EPOCH_FIRST;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == kuf_pkg::S_CLEAR) begin
                r_clr_addr <= AW'(r_clr_addr + 1'b1);
                if (r_clr_addr == AW'(MAX_VERTICES - 1)) begin
                    r_epoch <= kuf_pkg::EPOCH_FIRST;
                end
            end
            if ((r_state == kuf_pkg::S_LINK) && take) begin
                r_sum <= sum_sat;
                if (r_cnt != kuf_pkg::COUNT_MAX) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                if (r_cmd.last) begin
                    r_sum      <= '0;
                    r_cnt      <= '0;
                    r_clr_addr <= '0;
                    if (r_epoch != kuf_pkg::EPOCH_LAST) begin
                        r_epoch <= r_epoch + 1'b1;
                    end
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_cur <= rd_addr;
        if (o_pop) begin
            r_cmd  <= i_head;
            r_take <= 1'b0;
        end
        if ((r_state == kuf_pkg::S_FIND_A) && rd_root) begin
            r_root_a <= r_cur;
        end
        if ((r_state == kuf_pkg::S_FIND_B) && rd_root) begin
            r_root_b <= r_cur;
        end
        if (r_state == kuf_pkg::S_LINK) begin
            r_take <= take;
        end
        if (out_load) begin
            r_result.tag        <= r_cmd.tag;
            r_result.accepted   <= r_take;
            r_result.bad_vertex <= r_cmd.bad;
            r_result.total      <= r_sum;
            r_result.taken      <= r_cnt;
            r_result.complete   <= complete;
            r_result.last       <= r_cmd.last;
        end
    end

    assign o_status.clearing = (r_state == kuf_pkg::S_CLEAR);
    assign o_out_valid       = r_out_valid;
    assign o_result          = r_result;

    `KUF_ASSERT_IMPL(a_epoch_live, r_state != kuf_pkg::S_CLEAR, r_epoch != '0, "epoch zero in use")
    `KUF_ASSERT_NEXT(a_count_step, (r_state == kuf_pkg::S_LINK) && take, (r_cnt == $past(r_cnt) + 1'b1) || ($past(r_cnt) == kuf_pkg::COUNT_MAX), "count did not follow link")
    `KUF_ASSERT_IMPL(a_result_from_done, $rose(r_out_valid), $past(r_state == kuf_pkg::S_DONE), "result raised outside done")

endmodule

// ----- src/kruskal_union_find_edge_filter.sv -----
// Kruskal edge filter: takes edges sorted by nondecreasing weight, keeps a
// union-find parent table over vertices 1..vertex_count and returns one
// result transaction per edge (accepted, bad vertex, running saturating
// total, accepted count, and on the last edge whether a spanning tree was
// completed). An edge with a bad vertex or a self-loop skips the walks;
// any other edge walks from its first vertex to its root, then from its
// second vertex to its root, then links; the single read port of the
// parent table, walked one link per cycle, sets the walk time, and with no
// path compression the hop counts depend on the order of the edges. The
// table uses an epoch tag per entry, so a last edge clears it without a
// sweep; after reset, and after every 15th graph, a clearing pass over all
// MAX_VERTICES entries runs during which no input transaction is taken
// (vertex_count may still be written). The user must write vertex_count
// only while the block is idle; the block itself does not enforce it.
module kruskal_union_find_edge_filter #(
    parameter int unsigned MAX_VERTICES = kuf_pkg::MAX_VERTICES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_wr_en,
    input  logic [kuf_pkg::VERTEX_W-1:0] i_cfg_wr_data,
    // edge input
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [kuf_pkg::VERTEX_W-1:0] i_first_vertex,
    input  logic [kuf_pkg::VERTEX_W-1:0] i_second_vertex,
    input  logic [kuf_pkg::WEIGHT_W-1:0] i_edge_weight,
    input  logic [kuf_pkg::TAG_W-1:0]    i_edge_tag,
    input  logic                         i_last_edge,
    // result output
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [kuf_pkg::TAG_W-1:0]    o_edge_tag_out,
    output logic                         o_accepted,
    output logic                         o_bad_vertex,
    output logic [kuf_pkg::SUM_W-1:0]    o_total_length,
    output logic [kuf_pkg::COUNT_W-1:0]  o_edges_taken,
    output logic                         o_tree_complete,
    output logic                         o_last_out
);

    // vertex count register
    logic [kuf_pkg::VERTEX_W-1:0] r_vertex_count;

    // front to queue
    logic               push;
    kuf_pkg::t_edge_cmd push_cmd;
    logic               q_full;

    // queue to back
    logic               pop;
    logic               q_empty;
    kuf_pkg::t_edge_cmd q_head;

    kuf_pkg::t_back_status back_status;
    kuf_pkg::t_result      result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= kuf_pkg::VCOUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_vertex_count <= i_cfg_wr_data;
        end
    end

    // front: range check and self-loop detection, then into the queue
    kuf_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_first_vertex  (i_first_vertex),
        .i_second_vertex (i_second_vertex),
        .i_edge_weight   (i_edge_weight),
        .i_edge_tag      (i_edge_tag),
        .i_last_edge     (i_last_edge),
        .i_vertex_count  (r_vertex_count),
        .i_full          (q_full),
        .i_status        (back_status),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    // short queue decouples input acceptance from the root walks
    kuf_queue #(
        .DEPTH (kuf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cmd),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_empty     (q_empty),
        .o_head      (q_head)
    );

    // back: root walks, link, totals, output register
    kuf_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_head         (q_head),
        .o_pop          (pop),
        .i_vertex_count (r_vertex_count),
        .o_status       (back_status),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result       (result)
    );

    // result fields out to ports
    assign o_edge_tag_out  = result.tag;
    assign o_accepted      = result.accepted;
    assign o_bad_vertex    = result.bad_vertex;
    assign o_total_length  = result.total;
    assign o_edges_taken   = result.taken;
    assign o_tree_complete = result.complete;
    assign o_last_out      = result.last;

endmodule
